// ===== rtl/core/sll_pkg.sv =====
// Shared types, codes and constants of the static linked list engine.
package sll_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int VALUE_W   = 32;
   localparam int KIND_W    = 3;
   localparam int POS_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 3;
   localparam int LENGTH_W  = 3;
   localparam int CFG_W     = 3;

   typedef logic [KIND_W-1:0]          kind_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [SLOT_W-1:0]          slot_type;
   typedef logic [LENGTH_W-1:0]        length_type;
   typedef logic [CFG_W-1:0]           cfg_type;

   localparam kind_type KIND_INIT   = 3'd0;
   localparam kind_type KIND_INSERT = 3'd1;
   localparam kind_type KIND_DELETE = 3'd2;
   localparam kind_type KIND_FIND   = 3'd3;
   localparam kind_type KIND_AMEND  = 3'd4;

   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_NOT_FOUND = 2'd1;
   localparam status_type STAT_FULL      = 2'd2;
   localparam status_type STAT_BAD_POS   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_INS_FREE,
      S_INS_WALK,
      S_INS_LINK,
      S_SRCH_HEAD,
      S_SRCH,
      S_DEL_FREE
   } state_type;

endpackage

// ===== rtl/core/static_linked_list_engine_top.sv =====
// Static linked list engine top level: operation sequencer over the slot store.
//
//  channel  ports                                           handshake
//  -------  ----------------------------------------------  ------------------------------
//  request  req_kind, req_position, req_value, req_new_value word taken when start && !busy
//  result   rsp_status, rsp_slot, rsp_length                 word on rsp_valid, one cycle
//  csr      csr_data                                         written when csr_valid && csr_ready
//
//  One link step per cycle through the store's read port sets the time per word.
//  Init sweeps every slot. Insert walks to the position and links in the free head slot.
//  Find/amend/delete walk the list. Bad position, full store, unknown kind: result next cycle.
//  After reset the block is busy sweeping the store to rebuild the free chain; csr words
//  are taken throughout. Results cannot be stalled; busy holds off new words.
module static_linked_list_engine_top #(
   parameter int SLOTS = sll_pkg::SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sll_pkg::kind_type    req_kind,
   input  sll_pkg::pos_type     req_position,
   input  sll_pkg::value_type   req_value,
   input  sll_pkg::value_type   req_new_value,
   output logic                 rsp_valid,
   output sll_pkg::status_type  rsp_status,
   output sll_pkg::slot_type    rsp_slot,
   output sll_pkg::length_type  rsp_length,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  sll_pkg::cfg_type     csr_data
);
   import sll_pkg::*;

   localparam int AW        = $clog2(SLOTS);
   localparam int CW        = AW + 1;
   localparam int MAX_ELEMS = SLOTS - 2;

   state_type     state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          report_ff, report_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] free_head_ff, free_head_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] nfree_ff, nfree_in;
   kind_type      kind_ff, kind_in;
   value_type     value_ff, value_in;
   value_type     new_value_ff, new_value_in;
   cfg_type       init_len_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   slot_type      rsp_slot_ff, rsp_slot_in;
   length_type    rsp_length_ff, rsp_length_in;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] link_rdata;
   value_type     val_rdata;
   logic          link_we;
   logic [AW-1:0] link_waddr;
   logic [AW-1:0] link_wdata;
   logic          val_we;
   logic [AW-1:0] val_waddr;
   value_type     val_wdata;

   logic [AW-1:0] preload_cnt;
   logic [CW-1:0] sweep_end;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] pos_ext;

   sll_store #(
      .SLOTS(SLOTS)
   ) u_store (
      .clock      (clock),
      .raddr      (rd_addr),
      .link_rdata (link_rdata),
      .val_rdata  (val_rdata),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .val_we     (val_we),
      .val_waddr  (val_waddr),
      .val_wdata  (val_wdata)
   );

   assign preload_cnt = (int'(init_len_ff) > MAX_ELEMS) ? AW'(MAX_ELEMS) : AW'(init_len_ff);
   assign sweep_end   = CW'(cnt_ff) + CW'(1);
   assign idx_ext     = CW'(idx_ff);
   assign pos_ext     = CW'(req_position);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         report_ff     <= 1'b0;
         head_ff       <= AW'(1);
         free_head_ff  <= AW'(2);
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         init_len_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         report_ff     <= report_in;
         head_ff       <= head_in;
         free_head_ff  <= free_head_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            init_len_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      rem_ff        <= rem_in;
      nfree_ff      <= nfree_in;
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      new_value_ff  <= new_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_length_ff <= rsp_length_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      report_in     = report_ff;
      head_in       = head_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      rem_in        = rem_ff;
      nfree_in      = nfree_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      new_value_in  = new_value_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_length_in = rsp_length_ff;
      rd_addr       = cur_ff;
      link_we       = 1'b0;
      link_waddr    = cur_ff;
      link_wdata    = free_head_ff;
      val_we        = 1'b0;
      val_waddr     = cur_ff;
      val_wdata     = new_value_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in      = req_kind;
               value_in     = req_value;
               new_value_in = req_new_value;
               case (req_kind)
                  KIND_INIT: begin
                     cnt_in       = preload_cnt;
                     idx_in       = '0;
                     report_in    = 1'b1;
                     head_in      = AW'(1);
                     free_head_in = (int'(preload_cnt) + 2 < SLOTS) ?
                                    AW'(int'(preload_cnt) + 2) : '0;
                     count_in     = preload_cnt;
                     state_in     = S_SWEEP;
                  end
                  KIND_INSERT: begin
                     if (pos_ext == '0 || pos_ext > CW'(count_ff) + CW'(1)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_BAD_POS;
                        rsp_slot_in   = '0;
                        rsp_length_in = LENGTH_W'(count_ff);
                     end else if (free_head_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_FULL;
                        rsp_slot_in   = '0;
                        rsp_length_in = LENGTH_W'(count_ff);
                     end else begin
                        rd_addr  = free_head_ff;
                        rem_in   = AW'(req_position - POS_W'(1));
                        state_in = S_INS_FREE;
                     end
                  end
                  KIND_DELETE, KIND_FIND, KIND_AMEND: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NOT_FOUND;
                        rsp_slot_in   = '0;
                        rsp_length_in = LENGTH_W'(count_ff);
                     end else begin
                        rd_addr  = head_ff;
                        state_in = S_SRCH_HEAD;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_slot_in   = '0;
                     rsp_length_in = LENGTH_W'(count_ff);
                  end
               endcase
            end
         end
         S_SWEEP: begin
            // element chain head -> 2 -> .. -> cnt+1, free chain from cnt+2 on
            link_we    = 1'b1;
            link_waddr = idx_ff;
            if (idx_ext == sweep_end || idx_ff == AW'(SLOTS - 1)) begin
               link_wdata = '0;
            end else begin
               link_wdata = idx_ff + AW'(1);
            end
            val_we    = (idx_ext >= CW'(2)) && (idx_ext <= sweep_end);
            val_waddr = idx_ff;
            val_wdata = VALUE_W'(idx_ff) - VALUE_W'(2);
            if (idx_ff == AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
               if (report_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_slot_in   = SLOT_W'(head_ff);
                  rsp_length_in = LENGTH_W'(count_ff);
               end
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_INS_FREE: begin
            nfree_in = link_rdata;
            rd_addr  = head_ff;
            cur_in   = head_ff;
            state_in = S_INS_WALK;
         end
         S_INS_WALK: begin
            if (rem_ff == '0) begin
               link_we    = 1'b1;
               link_waddr = free_head_ff;
               link_wdata = link_rdata;
               val_we     = 1'b1;
               val_waddr  = free_head_ff;
               val_wdata  = value_ff;
               state_in   = S_INS_LINK;
            end else begin
               cur_in  = link_rdata;
               rd_addr = link_rdata;
               rem_in  = rem_ff - AW'(1);
            end
         end
         S_INS_LINK: begin
            link_we       = 1'b1;
            link_waddr    = cur_ff;
            link_wdata    = free_head_ff;
            free_head_in  = nfree_ff;
            count_in      = count_ff + AW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in   = SLOT_W'(free_head_ff);
            rsp_length_in = LENGTH_W'(count_ff + AW'(1));
            state_in      = S_IDLE;
         end
         S_SRCH_HEAD: begin
            if (link_rdata == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOT_FOUND;
               rsp_slot_in   = '0;
               rsp_length_in = LENGTH_W'(count_ff);
               state_in      = S_IDLE;
            end else begin
               prev_in  = head_ff;
               cur_in   = link_rdata;
               rd_addr  = link_rdata;
               rem_in   = count_ff - AW'(1);
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (val_rdata == value_ff) begin
               if (kind_ff == KIND_DELETE) begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = link_rdata;
                  state_in   = S_DEL_FREE;
               end else begin
                  if (kind_ff == KIND_AMEND) begin
                     val_we    = 1'b1;
                     val_waddr = cur_ff;
                     val_wdata = new_value_ff;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_slot_in   = SLOT_W'(cur_ff);
                  rsp_length_in = LENGTH_W'(count_ff);
                  state_in      = S_IDLE;
               end
            end else if (rem_ff == '0 || link_rdata == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOT_FOUND;
               rsp_slot_in   = '0;
               rsp_length_in = LENGTH_W'(count_ff);
               state_in      = S_IDLE;
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rdata;
               rd_addr = link_rdata;
               rem_in  = rem_ff - AW'(1);
            end
         end
         S_DEL_FREE: begin
            // freed slot goes to the front of the free chain
            link_we       = 1'b1;
            link_waddr    = cur_ff;
            link_wdata    = free_head_ff;
            free_head_in  = cur_ff;
            count_in      = count_ff - AW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in   = SLOT_W'(cur_ff);
            rsp_length_in = LENGTH_W'(count_ff - AW'(1));
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_length = rsp_length_ff;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither in work nor answered");

   a_head_not_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (free_head_ff != head_ff))
      else $error("head slot on the free chain");

   a_full_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((free_head_ff == '0) == (count_ff == AW'(MAX_ELEMS))))
      else $error("free chain and element count disagree");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (int'(count_ff) <= MAX_ELEMS))
      else $error("element count beyond store capacity");

endmodule

// ===== rtl/core/sll_store.sv =====
// Slot store: link memory and value memory, one shared read address, registered reads.
module sll_store #(
   parameter int SLOTS = sll_pkg::SLOTS_DEF
) (
   input  logic                        clock,
   input  logic [$clog2(SLOTS)-1:0]    raddr,
   output logic [$clog2(SLOTS)-1:0]    link_rdata,
   output sll_pkg::value_type          val_rdata,
   input  logic                        link_we,
   input  logic [$clog2(SLOTS)-1:0]    link_waddr,
   input  logic [$clog2(SLOTS)-1:0]    link_wdata,
   input  logic                        val_we,
   input  logic [$clog2(SLOTS)-1:0]    val_waddr,
   input  sll_pkg::value_type          val_wdata
);
   import sll_pkg::*;

   localparam int AW = $clog2(SLOTS);

   logic [AW-1:0] link_mem [SLOTS];
   value_type     val_mem  [SLOTS];
   logic [AW-1:0] link_rd_ff;
   value_type     val_rd_ff;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      val_rd_ff <= val_mem[raddr];
   end

   assign link_rdata = link_rd_ff;
   assign val_rdata  = val_rd_ff;

endmodule
